// ===== rtl/core/lcws_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation and register codes and the controller state type
// for the load-cell weight and stability block. No dependencies.
package lcws_pkg;

	// Default geometry and scale factor.
	localparam int unsigned LCWS_WINDOW = 8;
	localparam logic [31:0] LCWS_DEFAULT_CPG = 32'd27525120;

	// Field widths fixed by the item format.
	localparam int unsigned OP_W = 2;
	localparam int unsigned RAW_W = 24;
	localparam int unsigned WEIGHT_W = 32;

	// The dividend is |raw - tare| * 100 (31 bits) shifted up by 16 bits.
	localparam int unsigned MAG_W = 31;
	localparam int unsigned DIV_BITS = MAG_W + 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

	// Operation codes of an input request.
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_TARE = 2'd1;
	localparam logic [OP_W-1:0] OP_RELOAD = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_CPG = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;
	localparam logic [1:0] REG_BAND = 2'd3;

	// Register reset values.
	localparam logic [15:0] TOL_RESET = 16'd50;
	localparam logic [15:0] BAND_RESET = 16'd25;

	// Saturation limits of the weight.
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WRITE,
		ST_SCAN,
		ST_CMP,
		ST_OUT
	} lcws_state_t;

endpackage

// ===== rtl/core/lcws_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result requests of the
// load-cell weight block. Depends on lcws_pkg.
interface lcws_in_if;
	import lcws_pkg::*;

	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic signed [RAW_W-1:0] raw_reading;

	modport source (output valid, op, raw_reading, input ready);
	modport sink (input valid, op, raw_reading, output ready);
endinterface

interface lcws_out_if;
	import lcws_pkg::*;

	logic valid;
	logic ready;
	logic signed [WEIGHT_W-1:0] weight;
	logic stable;
	logic saturated;

	modport source (output valid, weight, stable, saturated, input ready);
	modport sink (input valid, weight, stable, saturated, output ready);
endinterface

// ===== rtl/core/load_cell_weight_stability_top.sv =====
`timescale 1ns / 1ps
// Load-cell tare, scale and stability detector with its configuration port.
// Depends on lcws_pkg and the channel interfaces in lcws_if.sv.
//
// Usage:
// - in_ch carries one request per averaged reading: op (sample, tare, reload)
//   and the signed 24-bit raw_reading. out_ch returns exactly one result per
//   request: weight in centigrams, stable and saturated.
// - A sample request takes a setup step, a bit-serial restoring divider (one
//   quotient bit per cycle), a step to store the weight, and, once the ring is
//   full, a sweep of the ring memory one entry per cycle for its minimum and
//   maximum and then a compare step. One request is in work at a time.
// - Tare and reload requests skip the divider and go straight to the output step, answering zero.
// - The result sits in an output register, so the next request is accepted
//   while a result still waits; a stalled receiver holds a finished request
//   in the last step until the output register frees up.
// - Reset clears the controller, the offset and the ring bookkeeping and loads
//   the register defaults. The ring memory itself is not cleared; entries are
//   read only after all of them were written since the last history clear.
// - The user must write registers over the APB port only while the block is idle; the block does not enforce it.
module load_cell_weight_stability_top #(
	parameter int unsigned WINDOW = lcws_pkg::LCWS_WINDOW,
	parameter logic [31:0] DEFAULT_COUNTS_PER_GRAM = lcws_pkg::LCWS_DEFAULT_CPG
) (
	input  logic clk,
	input  logic arst_n,
	lcws_in_if.sink in_ch,
	lcws_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lcws_pkg::*;

	localparam int unsigned PTR_W = $clog2(WINDOW);
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);

	// Configuration registers.
	logic [31:0] cpg_q;
	logic signed [RAW_W-1:0] offset_q;
	logic [15:0] tol_q;
	logic [15:0] band_q;

	// Controller and bookkeeping.
	lcws_state_t st_q, st_next;
	logic signed [RAW_W-1:0] tare_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] sc_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Datapath registers.
	logic signed [RAW_W-1:0] raw_q;
	logic neg_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic signed [WEIGHT_W-1:0] lo_q, hi_q, rd_q;
	logic signed [WEIGHT_W-1:0] wk_weight_q;
	logic wk_stable_q, wk_sat_q;

	// Output register.
	logic res_valid_q;
	logic signed [WEIGHT_W-1:0] res_weight_q;
	logic res_stable_q, res_sat_q;

	// Ring memory.
	logic signed [WEIGHT_W-1:0] ring_mem [WINDOW];

	// Control decoded from the state.
	logic in_acc, cfg_we, mem_we, load_out, full_now, zero_op;
	logic [PTR_W-1:0] rd_addr;

	// Combinational datapath values.
	logic signed [RAW_W:0] diff;
	logic [RAW_W:0] mag;
	logic [31:0] prod;
	logic [32:0] trial;
	logic ge;
	logic sat;
	logic [31:0] wmag;
	logic signed [WEIGHT_W-1:0] w_val;
	logic [32:0] spread;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign zero_op = (in_ch.op == OP_TARE) || (in_ch.op == OP_RELOAD);
	assign full_now = (fill_q == CNT_W'(WINDOW - 1)) || (fill_q == CNT_W'(WINDOW));

	assign out_ch.valid = res_valid_q;
	assign out_ch.weight = res_weight_q;
	assign out_ch.stable = res_stable_q;
	assign out_ch.saturated = res_sat_q;

	// Register write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpg_q <= '0;
			offset_q <= '0;
			tol_q <= TOL_RESET;
			band_q <= BAND_RESET;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_CPG: cpg_q <= pwdata;
				REG_OFFSET: offset_q <= pwdata[RAW_W-1:0];
				REG_TOL: tol_q <= pwdata[15:0];
				REG_BAND: band_q <= pwdata[15:0];
			endcase
		end
	end

	// Register read port.
	always_comb begin
		unique case (paddr[3:2])
			REG_CPG: prdata = cpg_q;
			REG_OFFSET: prdata = {{(32 - RAW_W){offset_q[RAW_W-1]}}, offset_q};
			REG_TOL: prdata = {16'b0, tol_q};
			REG_BAND: prdata = {16'b0, band_q};
		endcase
	end

	// Next-state logic.
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					st_next = zero_op ? ST_OUT : ST_PREP;
				end
			end
			ST_PREP: st_next = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					st_next = ST_WRITE;
				end
			end
			ST_WRITE: st_next = full_now ? ST_SCAN : ST_OUT;
			ST_SCAN: begin
				if (sc_q == CNT_W'(WINDOW)) begin
					st_next = ST_CMP;
				end
			end
			ST_CMP: st_next = ST_OUT;
			ST_OUT: begin
				if (load_out) begin
					st_next = ST_IDLE;
				end
			end
			default: st_next = ST_IDLE;
		endcase
	end

	// Control outputs of the controller.
	always_comb begin
		in_ch.ready = (st_q == ST_IDLE);
		mem_we = (st_q == ST_WRITE);
		load_out = (st_q == ST_OUT) && (!res_valid_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_next;
		end
	end

	// Offset difference, magnitude and scaling by 100.
	always_comb begin
		diff = {raw_q[RAW_W-1], raw_q} - {tare_q[RAW_W-1], tare_q};
		mag = diff[RAW_W] ? (~diff + 1'b1) : diff;
		prod = 32'(mag) * 32'd100;
	end

	// One restoring division step: compare the shifted remainder with the divisor.
	always_comb begin
		trial = {rem_q, quo_q[DIV_BITS-1]};
		ge = (trial >= {1'b0, div_q});
	end

	// Clamp to 32 bits, restore the sign and apply the zero band.
	always_comb begin
		if (neg_q) begin
			sat = (quo_q > DIV_BITS'(WEIGHT_MIN));
		end else begin
			sat = (quo_q[DIV_BITS-1:31] != '0);
		end
		if (sat) begin
			wmag = neg_q ? WEIGHT_MIN : WEIGHT_MAX;
		end else begin
			wmag = quo_q[31:0];
		end
		if (quo_q < DIV_BITS'(band_q)) begin
			w_val = '0;
		end else begin
			w_val = neg_q ? -$signed(wmag) : $signed(wmag);
		end
	end

	// Ring sweep address and window spread.
	assign rd_addr = (sc_q < CNT_W'(WINDOW)) ? sc_q[PTR_W-1:0] : '0;
	assign spread = {hi_q[WEIGHT_W-1], hi_q} - {lo_q[WEIGHT_W-1], lo_q};

	// Ring memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wp_q] <= w_val;
		end
		rd_q <= ring_mem[rd_addr];
	end

	// Offset, ring bookkeeping and sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			sc_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if ((st_q == ST_IDLE) && in_acc && zero_op) begin
				tare_q <= (in_ch.op == OP_TARE) ? in_ch.raw_reading : offset_q;
				wp_q <= '0;
				fill_q <= '0;
			end
			if (st_q == ST_PREP) begin
				div_cnt_q <= DIV_CNT_W'(DIV_BITS - 1);
			end else if (st_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (st_q == ST_WRITE) begin
				wp_q <= (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != CNT_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
				sc_q <= '0;
			end else if (st_q == ST_SCAN) begin
				sc_q <= sc_q + 1'b1;
			end
		end
	end

	// Working datapath: operands, bit-serial divider and min/max sweep.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q <= in_ch.raw_reading;
			wk_weight_q <= '0;
			wk_stable_q <= 1'b0;
			wk_sat_q <= 1'b0;
		end
		unique case (st_q)
			ST_PREP: begin
				neg_q <= diff[RAW_W];
				quo_q <= {prod[MAG_W-1:0], 16'b0};
				rem_q <= '0;
				div_q <= (cpg_q == '0) ? DEFAULT_COUNTS_PER_GRAM : cpg_q;
			end
			ST_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
				quo_q <= {quo_q[DIV_BITS-2:0], ge};
			end
			ST_WRITE: begin
				wk_weight_q <= w_val;
				wk_sat_q <= sat;
				wk_stable_q <= 1'b0;
			end
			ST_SCAN: begin
				if (sc_q == CNT_W'(1)) begin
					lo_q <= rd_q;
					hi_q <= rd_q;
				end else if (sc_q != '0) begin
					if (rd_q < lo_q) begin
						lo_q <= rd_q;
					end
					if (rd_q > hi_q) begin
						hi_q <= rd_q;
					end
				end
			end
			ST_CMP: wk_stable_q <= (spread <= {17'b0, tol_q});
			default: begin
			end
		endcase
	end

	// Output register: loads a finished result, frees when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_weight_q <= wk_weight_q;
			res_stable_q <= wk_stable_q;
			res_sat_q <= wk_sat_q;
		end
	end

	// The fill count never runs past the ring depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond ring depth");

	// A tare or reload request clears the ring history.
	a_clear_history: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && zero_op) |=> (fill_q == '0) && (wp_q == '0))
		else $error("history not cleared by tare or reload");

	// A stable result comes only from a full ring.
	a_stable_full: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && wk_stable_q) |-> (fill_q == CNT_W'(WINDOW)))
		else $error("stable result from a partly filled ring");

	// A saturated result carries one of the two limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_sat_q) |->
			((res_weight_q == WEIGHT_MAX) || (res_weight_q == WEIGHT_MIN)))
		else $error("saturated weight is not a limit");

endmodule
